### src/rgbw_pixel_output_stage_defines.svh
// Assertion macros used by the checker file of the RGBW output stage.
`ifndef RGBW_PIXEL_OUTPUT_STAGE_DEFINES_SVH
`define RGBW_PIXEL_OUTPUT_STAGE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define RGBW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RGBW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/rgbw_pkg.sv
package rgbw_pkg;

  typedef enum logic [1:0] {
    MODE_WARM   = 2'd0,
    MODE_COLOUR = 2'd1,
    MODE_TURBO  = 2'd2
  } output_mode_e;

  // Configuration register indexes.
  localparam logic CFG_MASTER = 1'b0;
  localparam logic CFG_MODE   = 1'b1;

  // Levels derived from the master level squared.
  typedef struct packed {
    logic [7:0] red_green;
    logic [7:0] blue;
    logic [7:0] white;
  } levels_t;

  // White share divisors of the three colour channels.
  localparam int KRed   = 255;
  localparam int KGreen = 140;
  localparam int KBlue  = 36;
  localparam int WhiteGain = 110;

  // Scaled channel: c * m * 256 / 100 = c * m * 64 / 25.
  localparam int ScaledW   = 17;
  localparam int PctDiv    = 25;
  localparam int PctShiftR = 15;
  localparam int PctRecip  = (1 << PctShiftR) / PctDiv;

  // Master squared mapping onto 0..255.
  localparam int TopWhite = 255;
  localparam int TopRg    = 220;
  localparam int TopBlue  = 200;
  localparam int SqDiv    = 10000;
  localparam int SqShiftR = 22;
  localparam int SqRecip  = (1 << SqShiftR) / SqDiv;

endpackage

### src/rgbw_pixel_output_stage.sv
// RGBW pixel output stage.
// Input words on s_axis carry one pixel: red [7:0], green [15:8], blue [23:16].
// Output words on m_axis carry red [7:0], green [15:8], blue [23:16] and
// white [31:24] drive levels. One output word is produced per input word.
// The cfg channel writes master_level (index 0) and output_mode (index 1);
// cfg_ready_o is always high. Write it only while no word is in flight.
// Words go from input acceptance to output valid through seven register
// stages: multiply, two steps of the divide by one hundred, two steps of the
// per-channel share divide, the minimum, and the output register. Throughput
// is one word per cycle while the receiver is ready. After a write, the warm
// white and turbo level mapping settles through the registers of rgbw_level_map.
// Reset clears both registers (warm white mode, master level zero) and empties
// the pipeline. When the receiver stalls, the output word holds and bubbles in
// the pipeline still close up, so input is taken until every stage is full.
module rgbw_pixel_output_stage #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // red_out, green_out, blue_out, white_out
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  localparam int ExtBits = FRACTION_BITS - 8;
  localparam int QW      = rgbw_pkg::ScaledW + ExtBits;
  localparam int TW      = ExtBits + 1;
  localparam int NStages = 7;
  localparam int NLanes  = 3;
  localparam int SW      = rgbw_pkg::ScaledW;

  logic [6:0]                master_q;
  rgbw_pkg::output_mode_e    mode_q;
  rgbw_pkg::levels_t         levels;

  logic [NStages-1:0] vld_q, vld_d, en;

  logic [14:0]   p_q   [NLanes];
  logic [14:0]   p1_q  [NLanes];
  logic [10:0]   qe1_q [NLanes];
  logic [SW-1:0] s2_q  [NLanes];
  logic [SW-1:0] s3_q  [NLanes];
  logic [SW-1:0] qs3_q [NLanes];
  logic [SW-1:0] s4_q  [NLanes];
  logic [QW-1:0] q4_q  [NLanes];
  logic [SW-1:0] s5_q  [NLanes];
  logic [QW-1:0] f5_q;
  logic [QW-1:0] fmin;
  logic [7:0]    chan_res [NLanes];
  logic [5:0]    pct_tab [rgbw_pkg::PctDiv];
  logic [QW+6:0] wprod;
  logic [QW+6:0] wsh;
  logic [7:0]    white_res;
  logic [31:0]   out_d, out_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= '0;
      mode_q   <= rgbw_pkg::MODE_WARM;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rgbw_pkg::CFG_MASTER: master_q <= cfg_data_i;
        rgbw_pkg::CFG_MODE:   mode_q   <= rgbw_pkg::output_mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  rgbw_level_map u_level_map (
    .clk_i    (clk_i),
    .master_i (master_q),
    .levels_o (levels)
  );

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[NStages-1] = !vld_q[NStages-1] || m_axis_tready;
    for (int i = NStages - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int i = 1; i < NStages; i++) begin
      vld_d[i] = en[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];

  // Remainder table for the divide by twenty-five: floor(r * 64 / 25).
  for (genvar i = 0; i < rgbw_pkg::PctDiv; i++) begin : g_pct
    localparam int V = (i * 64) / rgbw_pkg::PctDiv;
    assign pct_tab[i] = 6'(V);
  end

  for (genvar g = 0; g < NLanes; g++) begin : g_lane
    localparam int K  = (g == 0) ? rgbw_pkg::KRed :
                        ((g == 1) ? rgbw_pkg::KGreen : rgbw_pkg::KBlue);
    localparam int RK = (1 << SW) / K;
    localparam int IW = $clog2(K);

    logic [TW-1:0] frac_tab [K];
    logic [25:0]   pe_prod;
    logic [14:0]   p_rem;
    logic [10:0]   qp;
    logic [4:0]    rp;
    logic [SW-1:0] s_val;
    logic [29:0]   se_prod;
    logic [SW-1:0] s_rem;
    logic [SW-1:0] qs;
    logic [SW-1:0] rs;
    logic [QW-1:0] q_val;
    logic [QW+7:0] kf;
    logic [QW+7:0] xk;
    logic [QW+7:0] diff;

    // floor(r * 2^ExtBits / K) for every remainder r below K.
    for (genvar i = 0; i < K; i++) begin : g_tab
      localparam longint V = (longint'(i) << ExtBits) / K;
      assign frac_tab[i] = TW'(V);
    end

    assign pe_prod = 26'(p_q[g]) * 26'(rgbw_pkg::PctRecip);
    assign se_prod = 30'(s2_q[g]) * 30'(RK);

    // Both quotient estimates fall short by at most one.
    always_comb begin
      p_rem = p1_q[g] - 15'(qe1_q[g]) * 15'(rgbw_pkg::PctDiv);
      if (p_rem >= 15'(rgbw_pkg::PctDiv)) begin
        qp = qe1_q[g] + 11'd1;
        rp = 5'(p_rem - 15'(rgbw_pkg::PctDiv));
      end else begin
        qp = qe1_q[g];
        rp = 5'(p_rem);
      end
      s_val = {qp, 6'b0} | SW'(pct_tab[rp]);

      s_rem = s3_q[g] - qs3_q[g] * SW'(K);
      if (s_rem >= SW'(K)) begin
        qs = qs3_q[g] + SW'(1);
        rs = s_rem - SW'(K);
      end else begin
        qs = qs3_q[g];
        rs = s_rem;
      end
      q_val = (QW'(qs) << ExtBits) | QW'(frac_tab[rs[IW-1:0]]);

      // The share never exceeds this channel's own, so the difference holds.
      kf   = (QW + 8)'(f5_q) * (QW + 8)'(K);
      xk   = (QW + 8)'(s5_q[g]) << ExtBits;
      diff = (xk - kf) >> FRACTION_BITS;
      chan_res[g] = (diff > (QW + 8)'(255)) ? 8'hFF : diff[7:0];
    end

    always_ff @(posedge clk_i) begin
      if (en[0]) begin
        p_q[g] <= 15'(s_axis_tdata[8*g +: 8]) * 15'(master_q);
      end
      if (en[1]) begin
        p1_q[g]  <= p_q[g];
        qe1_q[g] <= 11'(pe_prod >> rgbw_pkg::PctShiftR);
      end
      if (en[2]) begin
        s2_q[g] <= s_val;
      end
      if (en[3]) begin
        s3_q[g]  <= s2_q[g];
        qs3_q[g] <= SW'(se_prod >> SW);
      end
      if (en[4]) begin
        s4_q[g] <= s3_q[g];
        q4_q[g] <= q_val;
      end
      if (en[5]) begin
        s5_q[g] <= s4_q[g];
      end
    end
  end

  always_comb begin
    fmin = q4_q[0];
    if (q4_q[1] < fmin) begin
      fmin = q4_q[1];
    end
    if (q4_q[2] < fmin) begin
      fmin = q4_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      f5_q <= fmin;
    end
  end

  assign wprod = (QW + 7)'(f5_q) * (QW + 7)'(rgbw_pkg::WhiteGain);
  assign wsh   = wprod >> FRACTION_BITS;
  assign white_res = (wsh > (QW + 7)'(255)) ? 8'hFF : wsh[7:0];

  always_comb begin
    case (mode_q)
      rgbw_pkg::MODE_COLOUR: out_d = {white_res, chan_res[2], chan_res[1], chan_res[0]};
      rgbw_pkg::MODE_TURBO:  out_d = {levels.white, levels.blue,
                                      levels.red_green, levels.red_green};
      default:               out_d = {levels.white, 24'h0};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[NStages-1]) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = vld_q[NStages-1];
  assign m_axis_tdata  = out_q;

endmodule

### src/rgbw_level_map.sv
module rgbw_level_map (
  input  logic                  clk_i,
  input  logic [6:0]            master_i,
  output rgbw_pkg::levels_t     levels_o
);

  localparam int NTops = 3;

  logic [13:0] sq_q;
  logic [21:0] prod_q [NTops];
  logic [21:0] prod2_q [NTops];
  logic [8:0]  qe_q [NTops];
  logic [7:0]  lvl_q [NTops];

  always_ff @(posedge clk_i) begin
    sq_q <= 14'(master_i) * 14'(master_i);
  end

  for (genvar t = 0; t < NTops; t++) begin : g_top
    localparam int Top = (t == 0) ? rgbw_pkg::TopRg :
                         ((t == 1) ? rgbw_pkg::TopBlue : rgbw_pkg::TopWhite);
    logic [30:0] est;
    logic [21:0] rem;
    logic [9:0]  quo;

    assign est = 31'(prod_q[t]) * 31'(rgbw_pkg::SqRecip);

    // The estimate falls short by at most one, so one correction step does.
    always_comb begin
      rem = prod2_q[t] - 22'(qe_q[t]) * 22'(rgbw_pkg::SqDiv);
      if (rem >= 22'(rgbw_pkg::SqDiv)) begin
        quo = 10'(qe_q[t]) + 10'd1;
      end else begin
        quo = 10'(qe_q[t]);
      end
    end

    always_ff @(posedge clk_i) begin
      prod_q[t]  <= 22'(sq_q) * 22'(Top);
      prod2_q[t] <= prod_q[t];
      qe_q[t]    <= 9'(est >> rgbw_pkg::SqShiftR);
      lvl_q[t]   <= (quo > 10'd255) ? 8'hFF : quo[7:0];
    end
  end

  assign levels_o.red_green = lvl_q[0];
  assign levels_o.blue      = lvl_q[1];
  assign levels_o.white     = lvl_q[2];

endmodule

### src/rgbw_sva.sv
`include "rgbw_pixel_output_stage_defines.svh"

module rgbw_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  `RGBW_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
  `RGBW_ASSERT(a_ready_when_free, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready, "input blocked although the output can move")
  `RGBW_ASSERT_RST(a_reset_empty, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind rgbw_pixel_output_stage rgbw_sva u_rgbw_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
